// ===== design/u16u8_pkg.sv =====
package u16u8_pkg;

  localparam int CFG_ADDR_W      = 3;
  localparam int CFG_DATA_W      = 32;
  localparam int QUEUE_DEPTH_DEF = 2;

  // register index taken from paddr above the byte offset
  localparam logic REG_BIG_ENDIAN = 1'b0;

  // upper six bits of a surrogate code unit
  localparam logic [5:0] SUR_HIGH_TAG = 6'b110110;
  localparam logic [5:0] SUR_LOW_TAG  = 6'b110111;

  typedef struct packed {
    logic [7:0] first_byte;
    logic [7:0] second_byte;
    logic       final_unit;
  } in_item_t;

  typedef struct packed {
    logic [7:0] utf8_byte;
    logic       last_of_run;
  } out_item_t;

  // work for the serializer: an optional lone high surrogate, then an optional code point
  typedef struct packed {
    logic        pre_valid;
    logic [9:0]  pre_bits;
    logic        main_valid;
    logic [20:0] main_cp;
  } u16u8_job_t;

endpackage

// ===== design/u16u8_front.sv =====
module u16u8_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  big_endian,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  u16u8_pkg::in_item_t   in_data,
  input  logic                  q_full,
  output logic                  q_push,
  output u16u8_pkg::u16u8_job_t q_job
);
  import u16u8_pkg::*;

  logic        held_r, held_nxt;
  logic [9:0]  held_bits_r, held_bits_nxt;
  logic [15:0] unit;
  logic        is_high, is_low, accept;
  u16u8_job_t  job;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  assign unit    = big_endian ? {in_data.first_byte, in_data.second_byte}
                              : {in_data.second_byte, in_data.first_byte};
  assign is_high = (unit[15:10] == SUR_HIGH_TAG);
  assign is_low  = (unit[15:10] == SUR_LOW_TAG);

  always_comb begin
    job           = '0;
    held_nxt      = held_r;
    held_bits_nxt = held_bits_r;
    if (accept) begin
      held_nxt      = 1'b0;
      held_bits_nxt = '0;
      if (held_r && is_low) begin
        // pair: 0x10000 + (hi << 10) + lo
        job.main_valid = 1'b1;
        job.main_cp    = {11'({1'b0, held_bits_r} + 11'd64), unit[9:0]};
      end else begin
        job.pre_valid = held_r;
        job.pre_bits  = held_bits_r;
        if (is_high && !in_data.final_unit) begin
          held_nxt      = 1'b1;
          held_bits_nxt = unit[9:0];
        end else begin
          job.main_valid = 1'b1;
          job.main_cp    = {5'b0, unit};
        end
      end
    end
  end

  assign q_push = accept && (job.pre_valid || job.main_valid);
  assign q_job  = job;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r      <= 1'b0;
      held_bits_r <= '0;
    end else begin
      held_r      <= held_nxt;
      held_bits_r <= held_bits_nxt;
    end
  end

endmodule

// ===== design/u16u8_queue.sv =====
module u16u8_queue #(
  parameter int DEPTH = u16u8_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  u16u8_pkg::u16u8_job_t push_job,
  output logic                  full,
  input  logic                  pop,
  output logic                  head_valid,
  output u16u8_pkg::u16u8_job_t head_job
);
  import u16u8_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  u16u8_job_t    slot_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;
  logic          do_push, do_pop;

  assign full       = (count_r == CW'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head_job   = slot_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

// ===== design/u16u8_back.sv =====
module u16u8_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_valid,
  input  u16u8_pkg::u16u8_job_t q_job,
  output logic                  q_pop,
  output logic                  out_valid,
  input  logic                  out_ready,
  output u16u8_pkg::out_item_t  out_data
);
  import u16u8_pkg::*;

  function automatic logic [2:0] utf8_len(input logic [20:0] cp);
    logic [2:0] n;
    if (cp[20:7] == '0) begin
      n = 3'd1;
    end else if (cp[20:11] == '0) begin
      n = 3'd2;
    end else if (cp[20:16] == '0) begin
      n = 3'd3;
    end else begin
      n = 3'd4;
    end
    return n;
  endfunction

  function automatic logic [7:0] utf8_at(input logic [20:0] cp, input logic [2:0] len,
                                         input logic [1:0] idx);
    logic [7:0] b;
    logic [1:0] from_end;
    from_end = len[1:0] - 2'd1 - idx;
    if (idx == 2'd0) begin
      case (len)
        3'd1:    b = {1'b0, cp[6:0]};
        3'd2:    b = {3'b110, cp[10:6]};
        3'd3:    b = {4'b1110, cp[15:12]};
        default: b = {5'b11110, cp[20:18]};
      endcase
    end else begin
      case (from_end)
        2'd0:    b = {2'b10, cp[5:0]};
        2'd1:    b = {2'b10, cp[11:6]};
        default: b = {2'b10, cp[17:12]};
      endcase
    end
    return b;
  endfunction

  u16u8_job_t  cur_r;
  logic        cur_valid_r;
  logic        seg_main_r;
  logic [1:0]  idx_r;
  logic        out_valid_r;
  out_item_t   out_r;

  logic [20:0] cp_sel;
  logic [2:0]  len;
  logic        emit_ok, end_seg, last, job_done, load;

  assign cp_sel   = seg_main_r ? cur_r.main_cp : {5'b0, SUR_HIGH_TAG, cur_r.pre_bits};
  assign len      = utf8_len(cp_sel);
  assign emit_ok  = cur_valid_r && (!out_valid_r || out_ready);
  assign end_seg  = (idx_r == len[1:0] - 2'd1);
  assign last     = end_seg && (seg_main_r || !cur_r.main_valid);
  assign job_done = emit_ok && last;
  assign load     = q_valid && (!cur_valid_r || job_done);
  assign q_pop    = load;

  always_ff @(posedge clk) begin
    if (load) begin
      cur_r <= q_job;
    end
    if (emit_ok) begin
      out_r.utf8_byte   <= utf8_at(cp_sel, len, idx_r);
      out_r.last_of_run <= last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      seg_main_r  <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        cur_valid_r <= 1'b1;
        seg_main_r  <= !q_job.pre_valid;
        idx_r       <= '0;
      end else if (job_done) begin
        cur_valid_r <= 1'b0;
      end else if (emit_ok) begin
        if (end_seg) begin
          seg_main_r <= 1'b1;
          idx_r      <= '0;
        end else begin
          idx_r <= idx_r + 2'd1;
        end
      end
      if (emit_ok) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ===== design/utf16_to_utf8_transcoder_core.sv =====
// Channel   Handshake                 Carries
// in_       in_valid / in_ready       one UTF-16 code unit as two bytes + final_unit
// out_      out_valid / out_ready     one UTF-8 byte + last_of_run
// cfg_      APB psel/penable/pwrite   big_endian at address 0
//
// The output runs one byte per cycle unless out_ready stalls it; an item yields
// 1 to 6 bytes, and a held high surrogate yields none though it is accepted.
// The front classifies an item in its accept cycle; the job is registered in
// the queue, then in the serializer, before its first byte reaches the output.
// Reset (rst_n low, synchronous) empties the queue, the serializer and the held
// surrogate, and clears big_endian.
// A stalled output stops the serializer; the front keeps taking items until the queue fills.
module utf16_to_utf8_transcoder_core #(
  parameter int QUEUE_DEPTH = u16u8_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  u16u8_pkg::in_item_t                in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output u16u8_pkg::out_item_t               out_data,
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [u16u8_pkg::CFG_ADDR_W-1:0]   cfg_paddr,
  input  logic [u16u8_pkg::CFG_DATA_W-1:0]   cfg_pwdata,
  output logic [u16u8_pkg::CFG_DATA_W-1:0]   cfg_prdata,
  output logic                               cfg_pready
);
  import u16u8_pkg::*;

  logic       big_endian_r;
  logic       reg_write;
  logic       q_full, q_push, q_pop, q_valid;
  u16u8_job_t push_job, head_job;

  assign cfg_pready = 1'b1;
  assign reg_write  = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready
                      && (cfg_paddr[2] == REG_BIG_ENDIAN);
  assign cfg_prdata = (cfg_paddr[2] == REG_BIG_ENDIAN) ? {{(CFG_DATA_W-1){1'b0}}, big_endian_r}
                                                       : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      big_endian_r <= 1'b0;
    end else if (reg_write) begin
      big_endian_r <= cfg_pwdata[0];
    end
  end

  u16u8_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .big_endian (big_endian_r),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_job      (push_job)
  );

  u16u8_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_job   (push_job),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_job   (head_job)
  );

  u16u8_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_job     (head_job),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== design/u16u8_checker.sv =====
module u16u8_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               out_valid,
  input logic                               out_ready,
  input u16u8_pkg::out_item_t               out_data,
  input logic                               cfg_psel,
  input logic                               cfg_penable,
  input logic                               cfg_pwrite,
  input logic [u16u8_pkg::CFG_ADDR_W-1:0]   cfg_paddr,
  input logic [u16u8_pkg::CFG_DATA_W-1:0]   cfg_pwdata,
  input logic [u16u8_pkg::CFG_DATA_W-1:0]   cfg_prdata
);
  import u16u8_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output item changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

  // a lead byte always has continuation bytes behind it
  a_lead_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.utf8_byte[7:6] == 2'b11 |-> !out_data.last_of_run)
    else $error("lead byte closes a run");

  a_ascii_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.utf8_byte[7] |-> out_data.last_of_run)
    else $error("ASCII byte inside a run");

  a_cfg_readback: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $past(cfg_psel && cfg_penable && cfg_pwrite
                          && cfg_paddr[2] == REG_BIG_ENDIAN)
    && cfg_paddr[2] == REG_BIG_ENDIAN |-> cfg_prdata[0] == $past(cfg_pwdata[0]))
    else $error("big_endian readback mismatch");

endmodule

bind utf16_to_utf8_transcoder_core u16u8_checker u_chk (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .out_data    (out_data),
  .cfg_psel    (cfg_psel),
  .cfg_penable (cfg_penable),
  .cfg_pwrite  (cfg_pwrite),
  .cfg_paddr   (cfg_paddr),
  .cfg_pwdata  (cfg_pwdata),
  .cfg_prdata  (cfg_prdata)
);

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import u16u8_pkg::*;

  localparam logic [CFG_ADDR_W-1:0] ADDR_BE    = CFG_ADDR_W'(4 * int'(REG_BIG_ENDIAN));
  localparam logic [CFG_ADDR_W-1:0] ADDR_SPARE = CFG_ADDR_W'(4);
  localparam logic [3:0] USE_PRED         = 4'hF;
  localparam int         DRAIN_CYCLES     = 16;
  localparam int         LONG_HOLD_CYCLES = 300;
  localparam int         WATCHDOG_LIMIT   = 3000;
  localparam int         PHASES           = 6;
  localparam int         UNITS_PER_PHASE  = 80;

  // one directed row: config, raw unit, and either typed bytes or USE_PRED
  typedef struct packed {
    logic        be;
    logic [7:0]  fb;
    logic [7:0]  sb;
    logic        fin;
    logic [3:0]  nexp;
    logic [47:0] bytes;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic cfg_pready;

  // predictor state
  logic        be_mode = 1'b0;
  logic [9:0]  held_bits = '0;
  logic        high_held = 1'b0;
  logic [7:0]  unit_bytes[$];
  out_item_t   utf8_expected_q[$];

  int  err_cnt = 0;
  int  idle_cycles = 0;
  bit  tx_idle_on = 1'b1;
  bit  rx_idle_on = 1'b1;
  bit  long_hold = 1'b0;

  dir_row_t dir_rows[$] = '{
    '{1'b0, 8'h00, 8'h00, 1'b0, 4'd1, 48'h00_0000_0000_00},
    '{1'b0, 8'h7F, 8'h00, 1'b0, 4'd1, 48'h7F_0000_0000_00},
    '{1'b0, 8'h80, 8'h00, 1'b0, 4'd2, 48'hC2_8000_0000_00},
    '{1'b0, 8'hFF, 8'h07, 1'b0, 4'd2, 48'hDF_BF00_0000_00},
    '{1'b0, 8'h00, 8'h08, 1'b0, 4'd3, 48'hE0_A080_0000_00},
    '{1'b0, 8'hFF, 8'hFF, 1'b0, 4'd3, 48'hEF_BFBF_0000_00},
    '{1'b0, 8'h00, 8'hDC, 1'b0, 4'd3, 48'hED_B080_0000_00},  // lone low surrogate
    '{1'b0, 8'h00, 8'hD8, 1'b0, 4'd0, 48'h0},                // high held, no bytes
    '{1'b0, 8'h00, 8'hDC, 1'b0, 4'd4, 48'hF0_9080_8000_00},  // U+10000
    '{1'b0, 8'hFF, 8'hDB, 1'b0, 4'd0, 48'h0},
    '{1'b0, 8'hFF, 8'hDF, 1'b0, 4'd4, 48'hF4_8FBF_BF00_00},  // U+10FFFF
    '{1'b0, 8'h3D, 8'hD8, 1'b0, USE_PRED, 48'h0},
    '{1'b0, 8'h41, 8'h00, 1'b0, USE_PRED, 48'h0},            // held high then ASCII
    '{1'b0, 8'h00, 8'hD8, 1'b0, USE_PRED, 48'h0},
    '{1'b0, 8'hFF, 8'hDB, 1'b0, USE_PRED, 48'h0},            // high after high
    '{1'b0, 8'h00, 8'hDC, 1'b1, USE_PRED, 48'h0},            // pair completed on final
    '{1'b0, 8'h12, 8'hDA, 1'b1, USE_PRED, 48'h0},            // high on final, not held
    '{1'b0, 8'h00, 8'hD8, 1'b0, USE_PRED, 48'h0},
    '{1'b0, 8'h00, 8'hD8, 1'b1, USE_PRED, 48'h0},            // six bytes
    '{1'b0, 8'h00, 8'hD8, 1'b0, USE_PRED, 48'h0},
    '{1'b0, 8'h00, 8'hE0, 1'b1, USE_PRED, 48'h0},            // held high then BMP
    '{1'b1, 8'h00, 8'h00, 1'b0, 4'd1, 48'h00_0000_0000_00},
    '{1'b1, 8'hD8, 8'h3D, 1'b0, USE_PRED, 48'h0},
    '{1'b1, 8'hDE, 8'h00, 1'b1, USE_PRED, 48'h0},
    '{1'b1, 8'h12, 8'h34, 1'b0, USE_PRED, 48'h0},
    '{1'b1, 8'hFF, 8'hFF, 1'b1, 4'd3, 48'hEF_BFBF_0000_00}
  };

  utf16_to_utf8_transcoder_core dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic void add_byte(logic [7:0] b);
    unit_bytes.insert(unit_bytes.size(), b);
  endfunction

  function automatic void emit_code_point(logic [20:0] cp);
    if (cp < 21'h80) begin
      add_byte(cp[7:0]);
    end else if (cp < 21'h800) begin
      add_byte({3'b110, cp[10:6]});
      add_byte({2'b10, cp[5:0]});
    end else if (cp < 21'h10000) begin
      add_byte({4'b1110, cp[15:12]});
      add_byte({2'b10, cp[11:6]});
      add_byte({2'b10, cp[5:0]});
    end else begin
      add_byte({5'b11110, cp[20:18]});
      add_byte({2'b10, cp[17:12]});
      add_byte({2'b10, cp[11:6]});
      add_byte({2'b10, cp[5:0]});
    end
  endfunction

  // bytes caused by one code unit; updates the held-surrogate state
  function automatic void utf8_of_unit(in_item_t u);
    logic [15:0] unit;
    unit_bytes.delete();
    unit = be_mode ? {u.first_byte, u.second_byte} : {u.second_byte, u.first_byte};
    if (high_held) begin
      high_held = 1'b0;
      if (unit[15:10] == SUR_LOW_TAG) begin
        emit_code_point(21'h10000 + {held_bits, unit[9:0]});
        held_bits = '0;
        return;
      end
      emit_code_point({5'b0, SUR_HIGH_TAG, held_bits});
      held_bits = '0;
    end
    if (unit[15:10] == SUR_HIGH_TAG && !u.final_unit) begin
      held_bits = unit[9:0];
      high_held = 1'b1;
    end else begin
      emit_code_point({5'b0, unit});
    end
  endfunction

  function automatic void queue_expected(in_item_t u, logic [3:0] nexp, logic [47:0] typed);
    int n;
    out_item_t r;
    utf8_of_unit(u);
    n = (nexp == USE_PRED) ? unit_bytes.size() : int'(nexp);
    for (int k = 0; k < n; k++) begin
      r.utf8_byte   = (nexp == USE_PRED) ? unit_bytes[k] : typed[47 - 8 * k -: 8];
      r.last_of_run = (k == n - 1);
      utf8_expected_q.insert(utf8_expected_q.size(), r);
    end
  endfunction

  task automatic send_unit(in_item_t u, logic [3:0] nexp, logic [47:0] typed);
    int gap;
    gap = tx_idle_on ? $urandom_range(0, 13) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= u;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    queue_expected(u, nexp, typed);
    @(negedge clk);
  endtask

  task automatic send_code(logic [15:0] unit, logic fin);
    in_item_t u;
    u.first_byte  = be_mode ? unit[15:8] : unit[7:0];
    u.second_byte = be_mode ? unit[7:0] : unit[15:8];
    u.final_unit  = fin;
    send_unit(u, USE_PRED, 48'h0);
  endtask

  task automatic cfg_access(logic wr, logic [CFG_ADDR_W-1:0] addr, logic [31:0] data,
                            output logic [31:0] rd);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    rd = cfg_prdata;
    if (wr && addr == ADDR_BE) be_mode = data[0];
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic check_big_endian();
    logic [31:0] rd;
    cfg_access(1'b0, ADDR_BE, 32'h0, rd);
    if (rd !== {31'b0, be_mode}) begin
      $error("big_endian: expected %0h, got %0h", {31'b0, be_mode}, rd);
      err_cnt++;
    end
  endtask

  // block idle: all bytes out, plus slack for an item that yields none
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (utf8_expected_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic send_random_phase();
    int sent;
    int cat;
    logic [15:0] unit;
    logic fin;
    sent = 0;
    while (sent < UNITS_PER_PHASE) begin
      cat = $urandom_range(0, 99);
      fin = ($urandom_range(0, 15) == 0);
      if (cat < 15) begin
        unit = 16'($urandom_range(0, 16'h7F));
      end else if (cat < 30) begin
        unit = 16'($urandom_range(16'h80, 16'h7FF));
      end else if (cat < 50) begin
        unit = 16'($urandom_range(16'h800, 16'hFFFF));
        if (unit[15:11] == 5'b11011) unit = unit ^ 16'h4000;
      end else if (cat < 80) begin
        // well-formed pair
        unit = {SUR_HIGH_TAG, 10'($urandom)};
        send_code(unit, 1'b0);
        sent++;
        unit = {SUR_LOW_TAG, 10'($urandom)};
      end else if (cat < 88) begin
        unit = {SUR_HIGH_TAG, 10'($urandom)};
      end else if (cat < 94) begin
        unit = {SUR_LOW_TAG, 10'($urandom)};
      end else begin
        unit = 16'($urandom);
      end
      send_code(unit, fin);
      sent++;
    end
    // close the stream so nothing is held across a config change
    send_code(16'($urandom), 1'b1);
  endtask

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_psel) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  initial begin : result_sink
    int stall;
    out_item_t exp_item;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if (long_hold) begin
        long_hold = 1'b0;
        stall = LONG_HOLD_CYCLES;
      end else begin
        stall = rx_idle_on ? $urandom_range(0, 13) : 0;
      end
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      if (utf8_expected_q.size() == 0) begin
        $error("unexpected item: utf8_byte %02h last_of_run %0b",
               out_data.utf8_byte, out_data.last_of_run);
        err_cnt++;
      end else begin
        exp_item = utf8_expected_q.pop_front();
        if (out_data.utf8_byte !== exp_item.utf8_byte) begin
          $error("utf8_byte: expected %02h, got %02h", exp_item.utf8_byte, out_data.utf8_byte);
          err_cnt++;
        end
        if (out_data.last_of_run !== exp_item.last_of_run) begin
          $error("last_of_run: expected %0b, got %0b",
                 exp_item.last_of_run, out_data.last_of_run);
          err_cnt++;
        end
      end
      @(negedge clk);
    end
  end

  initial begin : stimulus
    logic [31:0] rd;
    logic be_sel;
    in_item_t u;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    check_big_endian();

    foreach (dir_rows[i]) begin
      if (dir_rows[i].be != be_mode) begin
        wait_idle();
        cfg_access(1'b1, ADDR_BE, {31'b0, dir_rows[i].be}, rd);
        check_big_endian();
      end
      u.first_byte  = dir_rows[i].fb;
      u.second_byte = dir_rows[i].sb;
      u.final_unit  = dir_rows[i].fin;
      send_unit(u, dir_rows[i].nexp, dir_rows[i].bytes);
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      wait_idle();
      be_sel = (ph == 0) ? 1'b0 : (ph == 1) ? 1'b1 : 1'($urandom);
      // upper data bits are don't-care for a 1-bit register
      cfg_access(1'b1, ADDR_BE, {31'($urandom), be_sel}, rd);
      if (ph == 2) cfg_access(1'b1, ADDR_SPARE, $urandom, rd);  // unmapped, ignored
      check_big_endian();
      tx_idle_on = (ph != 3);
      rx_idle_on = (ph != 4);
      if (ph == 2) long_hold = 1'b1;
      send_random_phase();
    end

    wait_idle();
    if (err_cnt == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
